### rtl/particle_pair_spring_force_defines.svh
`ifndef PARTICLE_PAIR_SPRING_FORCE_DEFINES_SVH
`define PARTICLE_PAIR_SPRING_FORCE_DEFINES_SVH

// same-cycle implication, reset excluded
`define PPSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppsf check failed");

// next-cycle implication, reset excluded
`define PPSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppsf check failed");

`endif

### rtl/ppsf_pkg.sv
package ppsf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int D_W       = POS_W + 1;
  localparam int SQ_W      = 2 * D_W;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int M_W       = SQ_STEPS;
  localparam int SREM_W    = M_W + 3;
  localparam int KE_W      = CFG_W + M_W;
  localparam int KE_LO_W   = D_W;
  localparam int KE_HI_W   = KE_W - KE_LO_W;
  localparam int N_W       = KE_W + D_W;
  localparam int Q_W       = 32;
  localparam int NH_W      = N_W - Q_W;
  localparam int DEN_W     = M_W + FRAC_BITS;
  localparam int REM_W     = DEN_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST      = 2'd1;

  localparam logic [POS_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] FORCE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0][D_W-1:0] ad;
    logic [2:0]          neg;
  } side_t;

endpackage

### rtl/particle_pair_spring_force.sv
// Hooke's-law spring force between a particle and its partner, signed Q15.16.
// A pair is taken in every cycle unless in_stall is high, and its force beat
// passes through separation and squared length, the one-bit-a-stage square
// root, stretch, stiffness and numerator products, the one-bit-a-stage
// divider of each axis, a saturation register and one output register.
// The whole pipeline holds while a result beat is stalled.
// Coincident positions give zero force. cfg_index 0 is stiffness, 1 is rest
// length; write them only while no pair is in flight.
`include "particle_pair_spring_force_defines.svh"

module particle_pair_spring_force import ppsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     in_own_x,
  input  logic [POS_W-1:0]     in_own_y,
  input  logic [POS_W-1:0]     in_own_z,
  input  logic [POS_W-1:0]     in_partner_x,
  input  logic [POS_W-1:0]     in_partner_y,
  input  logic [POS_W-1:0]     in_partner_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_force_x,
  output logic [POS_W-1:0]     out_force_y,
  output logic [POS_W-1:0]     out_force_z,
  output logic                 out_clipped
);

  logic [CFG_W-1:0] stiff_r;
  logic [CFG_W-1:0] rest_r;
  logic             adv;

  logic             out_valid_r;
  logic [POS_W-1:0] fx_r, fy_r, fz_r;
  logic             clip_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= CFG_W'(32'd65536);
      rest_r  <= CFG_W'(32'd65536);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STIFFNESS: stiff_r <= cfg_data;
        CFG_REST:      rest_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // separation
  logic [2:0][POS_W-1:0] own, partner;
  side_t                 s0_nxt;
  assign own     = {in_own_z, in_own_y, in_own_x};
  assign partner = {in_partner_z, in_partner_y, in_partner_x};

  always_comb begin
    logic signed [D_W-1:0] d;
    s0_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({own[i][POS_W-1], own[i]}) - $signed({partner[i][POS_W-1], partner[i]});
      s0_nxt.neg[i] = (d > 0);
      s0_nxt.ad[i]  = d[D_W-1] ? D_W'(-d) : D_W'(d);
    end
  end

  logic                 s0_valid_r, s1_valid_r, s2_valid_r;
  side_t                s0_side_r, s1_side_r, s2_side_r;
  logic [2:0][SQ_W-1:0] s1_sq_r;
  logic [SQ_W-1:0]      s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= s0_nxt;
      s1_side_r <= s0_side_r;
      s2_side_r <= s1_side_r;
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i] <= SQ_W'(s0_side_r.ad[i]) * SQ_W'(s0_side_r.ad[i]);
      end
      s2_sum_r <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    end
  end

  logic           sq_valid;
  logic [M_W-1:0] sq_root;
  side_t          sq_side;

  ppsf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s2_valid_r),
    .in_rad    (s2_sum_r),
    .in_side   (s2_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stretch, stiffness, numerators
  logic                  e_valid_r, k_valid_r, p1_valid_r, p2_valid_r;
  side_t                 e_side_r, k_side_r, p1_side_r, p2_side_r;
  logic [M_W-1:0]        e_ext_r;
  logic [DEN_W-1:0]      e_den_r, k_den_r, p1_den_r, p2_den_r;
  logic                  e_zero_r, k_zero_r, p1_zero_r, p2_zero_r;
  logic [KE_W-1:0]       k_ke_r;
  logic [2:0][N_W-1:0]   p1_lo_r, p1_hi_r;
  logic [2:0][N_W-1:0]   p2_num_r;
  logic [M_W-1:0]        rest_ext;

  assign rest_ext = M_W'(rest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r  <= 1'b0;
      k_valid_r  <= 1'b0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r  <= sq_valid;
      k_valid_r  <= e_valid_r;
      p1_valid_r <= k_valid_r;
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side_r  <= sq_side;
      e_ext_r   <= (sq_root >= rest_ext) ? sq_root - rest_ext : rest_ext - sq_root;
      e_den_r   <= DEN_W'(sq_root) << FRAC_BITS;
      e_zero_r  <= (sq_root == '0);

      k_side_r  <= e_side_r;
      k_den_r   <= e_den_r;
      k_zero_r  <= e_zero_r;
      k_ke_r    <= KE_W'(stiff_r) * KE_W'(e_ext_r);

      p1_side_r <= k_side_r;
      p1_den_r  <= k_den_r;
      p1_zero_r <= k_zero_r;
      for (int i = 0; i < 3; i++) begin
        p1_lo_r[i] <= N_W'(k_ke_r[KE_LO_W-1:0]) * N_W'(k_side_r.ad[i]);
        p1_hi_r[i] <= N_W'(k_ke_r[KE_W-1:KE_LO_W]) * N_W'(k_side_r.ad[i]);
      end

      p2_side_r <= p1_side_r;
      p2_den_r  <= p1_den_r;
      p2_zero_r <= p1_zero_r;
      for (int i = 0; i < 3; i++) begin
        p2_num_r[i] <= p1_lo_r[i] + (p1_hi_r[i] << KE_LO_W);
      end
    end
  end

  logic [2:0]            dv_valid;
  logic [2:0][POS_W-1:0] dv_force;
  logic [2:0]            dv_clip;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ppsf_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (p2_valid_r),
      .in_num    (p2_num_r[i]),
      .in_den    (p2_den_r),
      .in_neg    (p2_side_r.neg[i]),
      .in_zero   (p2_zero_r),
      .out_valid (dv_valid[i]),
      .out_force (dv_force[i]),
      .out_clip  (dv_clip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r   <= dv_force[0];
      fy_r   <= dv_force[1];
      fz_r   <= dv_force[2];
      clip_r <= |dv_clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_force_x = fx_r;
  assign out_force_y = fy_r;
  assign out_force_z = fz_r;
  assign out_clipped = clip_r;

  `PPSF_ASSERT_NOW(a_lanes_agree, 1'b1, dv_valid[0] == dv_valid[1] && dv_valid[0] == dv_valid[2])
  `PPSF_ASSERT_NOW(a_clip_extreme, out_valid_r && clip_r, fx_r == FORCE_MAX || fx_r == FORCE_MIN || fy_r == FORCE_MAX || fy_r == FORCE_MIN || fz_r == FORCE_MAX || fz_r == FORCE_MIN)
  `PPSF_ASSERT_NEXT(a_hold_stalled, out_valid_r && out_stall, out_valid_r && $stable(fx_r) && $stable(clip_r))

endmodule

### rtl/ppsf_sqrt.sv
module ppsf_sqrt import ppsf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [SQ_W-1:0] in_rad,
  input  side_t           in_side,
  output logic            out_valid,
  output logic [M_W-1:0]  out_root,
  output side_t           out_side
);

  logic              valid_r [SQ_STEPS];
  logic [SQ_W-1:0]   rad_r   [SQ_STEPS];
  logic [M_W-1:0]    root_r  [SQ_STEPS];
  logic [SREM_W-1:0] rem_r   [SQ_STEPS];
  side_t             side_r  [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_st
    logic              pv;
    logic [SQ_W-1:0]   prad;
    logic [M_W-1:0]    proot;
    logic [SREM_W-1:0] prem;
    side_t             pside;
    logic [SREM_W-1:0] sh;
    logic [SREM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign proot = '0;
      assign prem  = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = valid_r[j-1];
      assign prad  = rad_r[j-1];
      assign proot = root_r[j-1];
      assign prem  = rem_r[j-1];
      assign pside = side_r[j-1];
    end

    assign sh    = {prem[SREM_W-3:0], prad[SQ_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (adv) begin
        valid_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[j]  <= prad << 2;
        side_r[j] <= pside;
        if (sh >= trial) begin
          rem_r[j]  <= sh - trial;
          root_r[j] <= {proot[M_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= sh;
          root_r[j] <= {proot[M_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

### rtl/ppsf_div.sv
module ppsf_div import ppsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [N_W-1:0]   in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic             in_neg,
  input  logic             in_zero,
  output logic             out_valid,
  output logic [POS_W-1:0] out_force,
  output logic             out_clip
);

  logic             chk_valid_r;
  logic [REM_W-1:0] chk_rem_r;
  logic [Q_W-1:0]   chk_low_r;
  logic [DEN_W-1:0] chk_den_r;
  logic             chk_big_r;
  logic             chk_neg_r;
  logic             chk_zero_r;

  logic             valid_r [Q_W];
  logic [REM_W-1:0] rem_r   [Q_W];
  logic [Q_W-1:0]   low_r   [Q_W];
  logic [Q_W-1:0]   q_r     [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic             big_r   [Q_W];
  logic             neg_r   [Q_W];
  logic             zero_r  [Q_W];

  logic             out_valid_r;
  logic [POS_W-1:0] force_r;
  logic             clip_r;

  logic [NH_W-1:0]  num_hi;
  assign num_hi = in_num[N_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else if (adv) begin
      chk_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chk_big_r  <= num_hi >= NH_W'(in_den);
      chk_rem_r  <= num_hi[REM_W-1:0];
      chk_low_r  <= in_num[Q_W-1:0];
      chk_den_r  <= in_den;
      chk_neg_r  <= in_neg;
      chk_zero_r <= in_zero;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    logic             pv;
    logic [REM_W-1:0] prem;
    logic [Q_W-1:0]   plow;
    logic [Q_W-1:0]   pq;
    logic [DEN_W-1:0] pden;
    logic             pbig;
    logic             pneg;
    logic             pzero;
    logic [REM_W-1:0] sh;

    if (j == 0) begin : g_first
      assign pv    = chk_valid_r;
      assign prem  = chk_rem_r;
      assign plow  = chk_low_r;
      assign pq    = '0;
      assign pden  = chk_den_r;
      assign pbig  = chk_big_r;
      assign pneg  = chk_neg_r;
      assign pzero = chk_zero_r;
    end else begin : g_next
      assign pv    = valid_r[j-1];
      assign prem  = rem_r[j-1];
      assign plow  = low_r[j-1];
      assign pq    = q_r[j-1];
      assign pden  = den_r[j-1];
      assign pbig  = big_r[j-1];
      assign pneg  = neg_r[j-1];
      assign pzero = zero_r[j-1];
    end

    assign sh = {prem[REM_W-2:0], plow[Q_W-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (adv) begin
        valid_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        low_r[j]  <= plow << 1;
        den_r[j]  <= pden;
        big_r[j]  <= pbig;
        neg_r[j]  <= pneg;
        zero_r[j] <= pzero;
        if (sh >= REM_W'(pden)) begin
          rem_r[j] <= sh - REM_W'(pden);
          q_r[j]   <= {pq[Q_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= sh;
          q_r[j]   <= {pq[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  logic [Q_W-1:0]   q_fin;
  logic [POS_W-1:0] force_nxt;
  logic             clip_nxt;
  assign q_fin = q_r[Q_W-1];

  always_comb begin
    force_nxt = POS_W'(q_fin);
    clip_nxt  = 1'b0;
    if (zero_r[Q_W-1]) begin
      force_nxt = '0;
    end else if (neg_r[Q_W-1]) begin
      if (big_r[Q_W-1] || ({1'b0, q_fin} > {1'b0, FORCE_MIN})) begin
        force_nxt = FORCE_MIN;
        clip_nxt  = 1'b1;
      end else begin
        force_nxt = POS_W'(-q_fin);
      end
    end else if (big_r[Q_W-1] || q_fin[Q_W-1]) begin
      force_nxt = FORCE_MAX;
      clip_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_r <= force_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_force = force_r;
  assign out_clip  = clip_r;

endmodule
